// ===== src/pfe_pkg.sv =====
package pfe_pkg;

  // Fixed widths of the character and result fields.
  localparam int TOKEN_WIDTH = 8;
  localparam int DIGIT_WIDTH = 4;
  localparam int RES_WIDTH   = 32;

  // Character codes that the front part recognizes.
  localparam logic [TOKEN_WIDTH-1:0] DIGIT_LOW  = 8'd48;
  localparam logic [TOKEN_WIDTH-1:0] DIGIT_END  = 8'd58;
  localparam logic [TOKEN_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [TOKEN_WIDTH-1:0] CHAR_MINUS = 8'h2D;

  // Operation that a classified character asks of the stack.
  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_PUSH = 2'd1,
    OP_ADD  = 2'd2,
    OP_SUB  = 2'd3
  } op_t;

  // Status reported with each result.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // One classified character, as it waits in the command queue.
  typedef struct packed {
    op_t                    op;
    logic [DIGIT_WIDTH-1:0] digit;
    logic                   last;
  } cmd_t;

  // One finished result.
  typedef struct packed {
    logic signed [RES_WIDTH-1:0] value;
    status_t                     status;
  } result_t;

endpackage

// ===== src/pfe_front.sv =====
module pfe_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [pfe_pkg::TOKEN_WIDTH-1:0]     in_token,
  input  logic                                in_last,
  output logic                                cmd_valid,
  output pfe_pkg::cmd_t                       cmd,
  input  logic                                cmd_ready
);

  pfe_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          accept;
  logic          deq;
  pfe_pkg::cmd_t cls;

  // Classify the incoming character into a stack operation.
  always_comb begin
    cls.last  = in_last;
    cls.digit = pfe_pkg::DIGIT_WIDTH'(in_token - pfe_pkg::DIGIT_LOW);
    if (in_token >= pfe_pkg::DIGIT_LOW && in_token < pfe_pkg::DIGIT_END) begin
      cls.op = pfe_pkg::OP_PUSH;
    end else if (in_token == pfe_pkg::CHAR_PLUS) begin
      cls.op = pfe_pkg::OP_ADD;
    end else if (in_token == pfe_pkg::CHAR_MINUS) begin
      cls.op = pfe_pkg::OP_SUB;
    end else begin
      cls.op = pfe_pkg::OP_NOP;
    end
  end

  // Two-entry command queue between the front and the back part.
  assign full      = (cnt_r == 2'd2);
  assign accept    = push & ~full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign deq       = cmd_valid & cmd_ready;

  always_comb begin
    wr_ptr_nxt = accept ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = deq ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(accept) - 2'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== src/pfe_back.sv =====
module pfe_back #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  pfe_pkg::cmd_t    cmd,
  output logic             cmd_ready,
  output logic             res_valid,
  output pfe_pkg::result_t res,
  input  logic             res_ready
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Stack body in memory; the top three entries are also held in registers.
  logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] top_r, top_nxt;
  logic [VALUE_WIDTH-1:0] sec_r, sec_nxt;
  logic [VALUE_WIDTH-1:0] third_r;
  logic [CW-1:0]          count_r, count_nxt, c_tok;
  logic                   ovf_r, ovf_nxt, ovf_tok;
  logic                   fire;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic                   third_from_sec;
  logic                   third_from_mem;

  // A result beat can only leave when the result queue has room.
  assign cmd_ready = ~cmd.last | res_ready;
  assign fire      = cmd_valid & cmd_ready;
  assign raddr     = AW'(count_r - CW'(4));

  // Execute one operation against the cached top of the stack.
  always_comb begin
    c_tok          = count_r;
    ovf_tok        = ovf_r;
    top_nxt        = top_r;
    sec_nxt        = sec_r;
    we             = 1'b0;
    waddr          = AW'(count_r);
    wdata          = top_r;
    third_from_sec = 1'b0;
    third_from_mem = 1'b0;
    if (fire) begin
      unique case (cmd.op)
        pfe_pkg::OP_PUSH: begin
          if (count_r < CW'(STACK_DEPTH)) begin
            we             = 1'b1;
            waddr          = AW'(count_r);
            wdata          = VALUE_WIDTH'(cmd.digit);
            top_nxt        = VALUE_WIDTH'(cmd.digit);
            sec_nxt        = top_r;
            third_from_sec = 1'b1;
            c_tok          = count_r + CW'(1);
          end else begin
            ovf_tok = 1'b1;
          end
        end
        pfe_pkg::OP_ADD, pfe_pkg::OP_SUB: begin
          if (count_r >= CW'(2)) begin
            top_nxt        = (cmd.op == pfe_pkg::OP_ADD) ? sec_r + top_r : sec_r - top_r;
            we             = 1'b1;
            waddr          = AW'(count_r - CW'(2));
            wdata          = top_nxt;
            sec_nxt        = third_r;
            third_from_mem = 1'b1;
            c_tok          = count_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Form the result on the last character and clear for the next expression.
  always_comb begin
    res_valid = fire & cmd.last;
    res.value = (c_tok != '0) ? pfe_pkg::RES_WIDTH'(signed'(top_nxt)) : '0;
    if (ovf_tok) begin
      res.status = pfe_pkg::ST_OVERFLOW;
    end else if (c_tok == '0) begin
      res.status = pfe_pkg::ST_EMPTY;
    end else begin
      res.status = pfe_pkg::ST_OK;
    end
    count_nxt = res_valid ? '0 : c_tok;
    ovf_nxt   = res_valid ? 1'b0 : ovf_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Cached entries carry payload only.
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    sec_r <= sec_nxt;
  end

  // Stack memory with a registered read that refills the third entry.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (third_from_mem) begin
      third_r <= mem[raddr];
    end else if (third_from_sec) begin
      third_r <= sec_r;
    end
  end

endmodule

// ===== src/pfe_result_q.sv =====
module pfe_result_q (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_valid,
  input  pfe_pkg::result_t                  res,
  output logic                              res_ready,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [pfe_pkg::RES_WIDTH-1:0] out_value,
  output logic [1:0]                        out_status
);

  pfe_pkg::result_t q_r [2];
  pfe_pkg::result_t head;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             enq;
  logic             deq;

  // Two-entry result queue so the back part keeps going while a beat waits.
  assign res_ready  = (cnt_r != 2'd2);
  assign enq        = res_valid & res_ready;
  assign empty      = (cnt_r == 2'd0);
  assign deq        = pop & ~empty;
  assign head       = q_r[rd_ptr_r];
  assign out_value  = head.value;
  assign out_status = head.status;

  always_comb begin
    wr_ptr_nxt = enq ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = deq ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(enq) - 2'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

// ===== src/postfix_digit_evaluator_core.sv =====
// Postfix evaluator: one ASCII character is taken per cycle, sustained, with no
// bubbles between expressions, as long as the consumer keeps the result queue from
// filling. Digits push, '+' and '-' combine the top two stack entries, and the
// character flagged last makes one result beat (top of stack and status) appear on
// the output queue: it passes the command queue, is evaluated, and is written into
// the result queue, from which it can be popped. The rate is set by the back part's
// single stack step per cycle: the top three entries live in registers and the stack
// memory is written once and read once per cycle. With two result beats waiting, a
// last character stalls the back part until a beat is popped, and the two-entry
// input queue then fills. The stack needs no clearing after reset; it is usable at once.
module postfix_digit_evaluator_core #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic [pfe_pkg::TOKEN_WIDTH-1:0]      in_token,
  input  logic                                 in_last,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [pfe_pkg::RES_WIDTH-1:0] out_value,
  output logic [1:0]                           out_status
);

  logic             cmd_valid;
  logic             cmd_ready;
  pfe_pkg::cmd_t    cmd;
  logic             res_valid;
  logic             res_ready;
  pfe_pkg::result_t res;

  // Front part: classify characters into the command queue.
  pfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_token  (in_token),
    .in_last   (in_last),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // Back part: run the operand stack.
  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Result queue toward the consumer.
  pfe_result_q u_result_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .empty      (empty),
    .pop        (pop),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Tracks the operand stack of the postfix evaluator and holds the result beats
// that the accepted characters must produce, in order.
class rpn_result_tracker #(int DEPTH = 64);
  logic [31:0]          stack_mem [DEPTH];
  int unsigned          depth_used;
  bit                   overflow_flag;
  pfe_pkg::result_t     pending_results [$];
  int unsigned          mismatches;
  int unsigned          results_checked;
  int unsigned          overflow_results;
  int unsigned          empty_results;

  function new();
    depth_used    = 0;
    overflow_flag = 0;
    mismatches    = 0;
    results_checked  = 0;
    overflow_results = 0;
    empty_results    = 0;
  endfunction

  // Applies one accepted character to the stack copy and queues a result on last.
  function void take_char(logic [7:0] ch, logic is_last);
    pfe_pkg::result_t res;
    if (ch >= pfe_pkg::DIGIT_LOW && ch < pfe_pkg::DIGIT_END) begin
      if (depth_used < DEPTH) begin
        stack_mem[depth_used] = 32'(ch - pfe_pkg::DIGIT_LOW);
        depth_used++;
      end else begin
        overflow_flag = 1'b1;
      end
    end else if ((ch == pfe_pkg::CHAR_PLUS || ch == pfe_pkg::CHAR_MINUS) && depth_used >= 2) begin
      if (ch == pfe_pkg::CHAR_PLUS) begin
        stack_mem[depth_used-2] = stack_mem[depth_used-2] + stack_mem[depth_used-1];
      end else begin
        stack_mem[depth_used-2] = stack_mem[depth_used-2] - stack_mem[depth_used-1];
      end
      depth_used--;
    end

    // The end of an expression reports the top and clears the stack.
    if (is_last) begin
      res.value = (depth_used > 0) ? stack_mem[depth_used-1] : '0;
      if (overflow_flag) begin
        res.status = pfe_pkg::ST_OVERFLOW;
      end else if (depth_used == 0) begin
        res.status = pfe_pkg::ST_EMPTY;
      end else begin
        res.status = pfe_pkg::ST_OK;
      end
      pending_results.push_back(res);
      depth_used    = 0;
      overflow_flag = 1'b0;
    end
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // Compares one accepted result beat with the oldest pending result.
  task check_result(logic signed [31:0] value, logic [1:0] status);
    pfe_pkg::result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result beat: value %0d status %0d", value, status));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (want.status == pfe_pkg::ST_OVERFLOW) overflow_results++;
    if (want.status == pfe_pkg::ST_EMPTY) empty_results++;
    if (value !== want.value) begin
      report($sformatf("result %0d value: got %0d, want %0d",
                       results_checked, value, want.value));
    end
    if (status !== want.status) begin
      report($sformatf("result %0d status: got %0d, want %0d",
                       results_checked, status, want.status));
    end
  endtask
endclass

module tb;

  localparam int STACK_DEPTH = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TARGET_ITEMS = 700;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_STREAM  = 2'd0,
    RX_COIN    = 2'd1,
    RX_SPARSE  = 2'd2,
    RX_CADENCE = 2'd3
  } rx_mode_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 push;
  logic                                 full;
  logic [pfe_pkg::TOKEN_WIDTH-1:0]      in_token;
  logic                                 in_last;
  logic                                 empty;
  logic                                 pop;
  logic signed [pfe_pkg::RES_WIDTH-1:0] out_value;
  logic [1:0]                           out_status;

  rpn_result_tracker #(STACK_DEPTH) tracker;

  logic [7:0]  expr_chars [$];
  int unsigned burst_left;
  int unsigned chars_sent;
  int unsigned useful_sent;
  int unsigned cycle_count;
  rx_mode_t    rx_mode;
  int unsigned rx_left;
  int unsigned rx_phase;

  postfix_digit_evaluator_core #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(32)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_token  (in_token),
    .in_last   (in_last),
    .empty     (empty),
    .pop       (pop),
    .out_value (out_value),
    .out_status(out_status)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with a hard stop on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, tracker.pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: pop follows a stall pattern that changes every so often.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_STREAM:  pop <= 1'b1;
      RX_COIN:    pop <= 1'($urandom_range(0, 1));
      RX_SPARSE:  pop <= ($urandom_range(0, 7) == 0);
      default:    pop <= ((rx_phase % 5) < 2);
    endcase
  end

  // Result beats are checked at the edge where they are taken.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      tracker.check_result(out_value, out_status);
    end
  end

  function automatic bit is_useful(logic [7:0] ch);
    return (ch >= pfe_pkg::DIGIT_LOW && ch < pfe_pkg::DIGIT_END) ||
           ch == pfe_pkg::CHAR_PLUS || ch == pfe_pkg::CHAR_MINUS;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (is_useful(ch)) ch = 8'($urandom_range(0, 255));
    return ch;
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(pfe_pkg::DIGIT_LOW + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] op_char();
    return $urandom_range(0, 1) ? pfe_pkg::CHAR_PLUS : pfe_pkg::CHAR_MINUS;
  endfunction

  // Sends one character beat, idling between bursts.
  task automatic send_char(logic [7:0] ch, logic is_last);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push     <= 1'b1;
    in_token <= ch;
    in_last  <= is_last;
    do @(posedge clk); while (full);
    tracker.take_char(ch, is_last);
    chars_sent++;
    if (is_useful(ch)) useful_sent++;
  endtask

  task automatic send_expression();
    for (int i = 0; i < expr_chars.size(); i++) begin
      send_char(expr_chars[i], i == expr_chars.size() - 1);
    end
  endtask

  // Builds a well-formed expression; front-loading pushes every digit first.
  task automatic build_wellformed(int unsigned pushes, bit front_load);
    int unsigned depth;
    depth = 0;
    expr_chars.delete();
    while (pushes > 0 || depth > 1) begin
      if (depth < 2 || (pushes > 0 && (front_load || $urandom_range(0, 1)))) begin
        expr_chars.push_back(digit_char());
        depth++;
        pushes--;
      end else begin
        expr_chars.push_back(op_char());
        depth--;
      end
      if ($urandom_range(0, 15) == 0) expr_chars.push_back(noise_char());
    end
    if ($urandom_range(0, 7) == 0) expr_chars.push_back(noise_char());
  endtask

  // Builds an arbitrary mix of digits, operators and other characters.
  task automatic build_broken(int unsigned len);
    int unsigned pick;
    expr_chars.delete();
    repeat (len) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) expr_chars.push_back(digit_char());
      else if (pick < 7) expr_chars.push_back(op_char());
      else expr_chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_directed(string text, logic [7:0] extra_first, bit use_extra);
    expr_chars.delete();
    if (use_extra) expr_chars.push_back(extra_first);
    for (int i = 0; i < text.len(); i++) expr_chars.push_back(8'(text.getc(i)));
    send_expression();
  endtask

  // Main sequence: reset, directed expressions, then random expressions.
  initial begin
    int unsigned pick;
    push        = 1'b0;
    pop         = 1'b0;
    in_token    = '0;
    in_last     = 1'b0;
    rst_n       = 1'b0;
    burst_left  = 0;
    chars_sent  = 0;
    useful_sent = 0;
    cycle_count = 0;
    rx_mode     = RX_STREAM;
    rx_left     = 0;
    rx_phase    = 0;
    tracker     = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty expression, single digits at both ends, and negative results.
    send_directed(" ", 8'h00, 1'b0);
    send_directed("0", 8'h00, 1'b0);
    send_directed("9", 8'h00, 1'b0);
    send_directed("09-", 8'h00, 1'b0);
    send_directed("123+-", 8'h00, 1'b0);
    // Operators that find fewer than two entries are ignored; the last one adds two.
    send_directed("+", 8'h00, 1'b0);
    send_directed("5+", 8'h00, 1'b0);
    send_directed("73+", 8'h00, 1'b0);
    // Characters just outside the digit range and at the byte extremes.
    send_directed("/2:", 8'h00, 1'b1);
    expr_chars.delete();
    expr_chars.push_back(8'hFF);
    send_expression();

    // Random expressions, mostly well-formed.
    while (useful_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_wellformed($urandom_range(1, 8), 1'b0);
      end else if (pick < 78) begin
        build_wellformed($urandom_range(9, 24), 1'b0);
      end else if (pick < 82) begin
        // Deep expressions fill the stack and may overflow it.
        build_wellformed($urandom_range(60, 70), 1'b1);
      end else begin
        build_broken($urandom_range(1, 10));
      end
      send_expression();
    end

    @(negedge clk);
    push <= 1'b0;

    // Drain the outstanding results, then keep watching for stray beats.
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d characters, %0d of them digits or operators.",
             chars_sent, useful_sent);
    $display("Checked %0d results: %0d overflowed, %0d ended empty, %0d mismatches.",
             tracker.results_checked, tracker.overflow_results,
             tracker.empty_results, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
